// File: sv/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

  // operand widths
  localparam int NUM_WIDTH = 32;
  // trial divisor reaches at most 2^(NUM_WIDTH/2)+3
  localparam int DIV_WIDTH = NUM_WIDTH / 2 + 2;
  // running square of (divisor-1), one step past the candidate at most
  localparam int SQ_WIDTH  = NUM_WIDTH + 2;
  // bit position within the candidate during a remainder pass
  localparam int BIT_WIDTH = $clog2(NUM_WIDTH);

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_BOUND,
    S_DIV,
    S_EVAL,
    S_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture a new candidate and reset the divisor
    logic start_div;   // clear the remainder and point at the top bit
    logic div_step;    // one restoring remainder step
    logic advance;     // next odd divisor and its bound square
    logic set_result;  // latch result_val as the answer
    logic result_val;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic trivial;         // 0, 1, 2 or even
    logic trivial_prime;   // the candidate is two
    logic bound_exceeded;  // (divisor-1)^2 > candidate
    logic div_last;        // final bit of the remainder pass
    logic rem_zero;        // remainder is zero
  } stat_t;

endpackage

// File: sv/ptd_datapath.sv
`timescale 1ns / 1ps

module ptd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ptd_pkg::cmd_t               cmd_i,
  input  logic [ptd_pkg::NUM_WIDTH-1:0] candidate_i,
  output ptd_pkg::stat_t              stat_o,
  output logic                        is_prime_o
);
  import ptd_pkg::*;

  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [DIV_WIDTH-1:0] d_q, d_d;
  logic [SQ_WIDTH-1:0]  sq_q, sq_d;
  logic [DIV_WIDTH:0]   r_q, r_d;
  logic [BIT_WIDTH-1:0] bit_q, bit_d;
  logic                 prime_q, prime_d;
  logic [DIV_WIDTH:0]   r_shift;

  // candidate, divisor and bound square
  always_comb begin
    n_d  = n_q;
    d_d  = d_q;
    sq_d = sq_q;
    if (cmd_i.load) begin
      n_d  = candidate_i;
      d_d  = DIV_WIDTH'(3);
      sq_d = SQ_WIDTH'(4);
    end else if (cmd_i.advance) begin
      // (q+2)^2 = q^2 + 4(q+1) with q = d-1
      d_d  = d_q + DIV_WIDTH'(2);
      sq_d = sq_q + SQ_WIDTH'({d_q, 2'b00});
    end
  end

  // restoring remainder, one candidate bit per cycle
  assign r_shift = {r_q[DIV_WIDTH-1:0], n_q[bit_q]};

  always_comb begin
    r_d   = r_q;
    bit_d = bit_q;
    if (cmd_i.start_div) begin
      r_d   = '0;
      bit_d = BIT_WIDTH'(NUM_WIDTH - 1);
    end else if (cmd_i.div_step) begin
      if (r_shift >= {1'b0, d_q}) begin
        r_d = r_shift - {1'b0, d_q};
      end else begin
        r_d = r_shift;
      end
      bit_d = bit_q - BIT_WIDTH'(1);
    end
  end

  // result bit
  always_comb begin
    prime_d = prime_q;
    if (cmd_i.set_result) begin
      prime_d = cmd_i.result_val;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    sq_q  <= sq_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= 1'b0;
    end else begin
      prime_q <= prime_d;
    end
  end

  // status
  assign stat_o.trivial_prime  = (n_q == NUM_WIDTH'(2));
  assign stat_o.trivial        = (n_q < NUM_WIDTH'(2)) || !n_q[0] || stat_o.trivial_prime;
  assign stat_o.bound_exceeded = (sq_q > SQ_WIDTH'(n_q));
  assign stat_o.div_last       = (bit_q == '0);
  assign stat_o.rem_zero       = (r_q == '0);

  assign is_prime_o = prime_q;

endmodule

// File: sv/ptd_ctrl.sv
`timescale 1ns / 1ps

module ptd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ptd_pkg::stat_t stat_i,
  output ptd_pkg::cmd_t  cmd_o
);
  import ptd_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_CLASSIFY;
      S_CLASSIFY: state_d = stat_i.trivial ? S_DONE : S_BOUND;
      S_BOUND:    state_d = stat_i.bound_exceeded ? S_DONE : S_DIV;
      S_DIV:      if (stat_i.div_last) state_d = S_EVAL;
      S_EVAL:     state_d = stat_i.rem_zero ? S_DONE : S_BOUND;
      S_DONE:     if (!out_stall_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // commands and handshake
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_CLASSIFY: begin
        cmd_o.set_result = stat_i.trivial;
        cmd_o.result_val = stat_i.trivial_prime;
      end
      S_BOUND: begin
        cmd_o.set_result = stat_i.bound_exceeded;
        cmd_o.result_val = 1'b1;
        cmd_o.start_div  = !stat_i.bound_exceeded;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_EVAL: begin
        cmd_o.set_result = stat_i.rem_zero;
        cmd_o.result_val = 1'b0;
        cmd_o.advance    = !stat_i.rem_zero;
      end
      S_DONE: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/primality_test_trial_division.sv
// result: 0, 1, 2 and even candidates are settled straight after classification; otherwise
//   odd divisors 3, 5, 7, ... are tried until one divides the candidate (composite) or
//   (divisor-1)^2 exceeds the candidate (prime)
// throughput: one item at a time, the next accept comes only after the result is taken;
//   each divisor: one bound check, a bit-serial remainder over NUM_WIDTH bits, one test
// reset: rst_ni asynchronous active low, returns the controller to idle with no result
`timescale 1ns / 1ps

module primality_test_trial_division (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ptd_pkg::NUM_WIDTH-1:0] candidate_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_prime_o
);
  import ptd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  ptd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // divisor, bound and remainder datapath
  ptd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .candidate_i (candidate_i),
    .stat_o      (stat),
    .is_prime_o  (is_prime_o)
  );

`ifndef SYNTH
  // no new item is taken while a result waits
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item accepted while a result is pending");

  // a result never shows in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result raised straight after accept");

  // even candidates other than two give not-prime by way of classify straight to done
  a_even_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !candidate_i[0] && candidate_i != NUM_WIDTH'(2))
      |-> ##2 (out_valid_o && !is_prime_o))
    else $error("even candidate not rejected");

  // datapath commands are exclusive of one another
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.start_div, cmd.div_step, cmd.advance, cmd.set_result}))
    else $error("conflicting datapath commands");
`endif

endmodule

// File: dv/tb_primality_test_trial_division.sv
`timescale 1ns / 1ps

module tb_primality_test_trial_division;
  import ptd_pkg::*;

  // one expected verdict together with the candidate that caused it
  typedef struct {
    logic [NUM_WIDTH-1:0] candidate;
    bit                   verdict;
  } verdict_t;

  // keeps the verdicts still owed by the block, oldest first
  class primality_scoreboard;
    verdict_t    pending_verdicts[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // odd divisors 3, 5, 7, ... while (d-1)^2 <= n, bound kept in divided form
    function bit trial_division_prime(logic [NUM_WIDTH-1:0] cand);
      longint unsigned n;
      longint unsigned d;
      longint unsigned q;
      n = cand;
      if (n == 2) return 1'b1;
      if (n < 2 || n[0] == 1'b0) return 1'b0;
      d = 3;
      q = 2;
      while (q <= n / q) begin
        if (n % d == 0) return 1'b0;
        d += 2;
        q = d - 1;
      end
      return 1'b1;
    endfunction

    function void note_candidate(logic [NUM_WIDTH-1:0] cand);
      verdict_t v;
      v.candidate = cand;
      v.verdict   = trial_division_prime(cand);
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic got);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual is_prime=%0b", $time, got);
        mismatches++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (got !== v.verdict) begin
        $display("%0t: candidate %0d: expected is_prime=%0b, actual is_prime=%0b",
                 $time, v.candidate, v.verdict, got);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [NUM_WIDTH-1:0] candidate_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 is_prime_o;

  primality_scoreboard sb = new();

  // edge values, small primes and squares on the divisor bound, large primes and composites
  logic [NUM_WIDTH-1:0] directed_candidates[] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15, 32'd25,
    32'd49, 32'd97, 32'd121, 32'd143, 32'd169, 32'd961, 32'd65521, 32'd65536,
    32'd1000003, 32'd1022117, 32'h5555_5555, 32'h8000_0000, 32'h8000_0001,
    32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  int unsigned small_primes[] = '{3, 5, 7, 11, 13};

  primality_test_trial_division dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .is_prime_o (is_prime_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // present one item and hold it until accepted
  task automatic send_candidate(input logic [NUM_WIDTH-1:0] cand);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    candidate_i <= cand;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_candidate(cand);
  endtask

  // idle the input for a number of cycles
  task automatic hold_off(input int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    candidate_i <= $urandom();
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // idle the input until every verdict has come back
  task automatic drain_verdicts();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // mostly cheap candidates, some mid-sized; large ones are even or odd multiples of a small prime
  function automatic logic [NUM_WIDTH-1:0] random_candidate();
    logic [NUM_WIDTH-1:0] r;
    int unsigned          p;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: return $urandom_range(0, 4095);
      11, 12, 13:                       return $urandom_range(4096, 262143);
      14, 15, 16:                       return $urandom() & ~32'h1;
      default: begin
        p = small_primes[$urandom_range(0, small_primes.size() - 1)];
        r = $urandom();
        r = r - r % p;
        if (r < p) return p;
        if (r[0] == 1'b0) r = r - p;
        return r;
      end
    endcase
  endfunction

  // receiver stall pattern in one of four randomly picked modes
  int unsigned stall_cycle = 0;
  int unsigned stall_mode  = 0;
  always @(negedge clk_i) begin
    stall_cycle++;
    if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      2:       out_stall_i <= ((stall_cycle % 9) < 4);
      default: out_stall_i <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_verdict(is_prime_o);
  end

  // stimulus
  initial begin
    int unsigned burst_left;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed candidates
    foreach (directed_candidates[i]) begin
      send_candidate(directed_candidates[i]);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
    end
    drain_verdicts();

    // random candidates in bursts with gaps
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < 75; i++) begin
      send_candidate(random_candidate());
      if (i == 37) drain_verdicts();
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 8));
      end
    end
    drain_verdicts();

    // catch any stray result
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
